// ----- rtl/gpb_pkg.sv -----
// Shared types and constants for the glyph pixel blend block.
// Payload structs, configuration struct, register indexes. No dependencies.
`default_nettype none

package gpb_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned ADDR_BITS  = 24;
  localparam int unsigned PITCH_W    = 13;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned COV_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [COV_W-1:0]      COV_OPAQUE     = 8'hFF;
  localparam logic [COV_W-1:0]      COV_NONE       = 8'h00;
  localparam logic [COLOR_W-1:0]    DRAW_COLOR_RST = 32'h0000_0000;
  localparam logic [COORD_BITS-1:0] CLIP_LEFT_RST  = 12'd0;
  localparam logic [COORD_BITS-1:0] CLIP_TOP_RST   = 12'd0;
  localparam logic [COORD_BITS-1:0] CLIP_RIGHT_RST = 12'd4095;
  localparam logic [COORD_BITS-1:0] CLIP_BOT_RST   = 12'd4095;
  localparam logic [PITCH_W-1:0]    LINE_PITCH_RST = 13'd1024;

  typedef enum logic {
    FUNC_GLYPH = 1'b0,
    FUNC_FILL  = 1'b1
  } gpb_func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRAW_COLOR  = 3'd0,
    REG_CLIP_LEFT   = 3'd1,
    REG_CLIP_TOP    = 3'd2,
    REG_CLIP_RIGHT  = 3'd3,
    REG_CLIP_BOTTOM = 3'd4,
    REG_LINE_PITCH  = 3'd5
  } gpb_reg_e;

  typedef struct packed {
    gpb_func_e              func;
    logic [COORD_BITS-1:0]  pos_x;
    logic [COORD_BITS-1:0]  pos_y;
    logic [COV_W-1:0]       coverage;
    logic [COLOR_W-1:0]     background;
  } gpb_in_t;

  typedef struct packed {
    logic                   write_enable;
    logic [ADDR_BITS-1:0]   address;
    logic [COLOR_W-1:0]     pixel;
  } gpb_out_t;

  typedef struct packed {
    logic [COLOR_W-1:0]     draw_color;
    logic [COORD_BITS-1:0]  clip_left;
    logic [COORD_BITS-1:0]  clip_top;
    logic [COORD_BITS-1:0]  clip_right;
    logic [COORD_BITS-1:0]  clip_bottom;
    logic [PITCH_W-1:0]     line_pitch;
  } gpb_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/glyph_pixel_blend.sv -----
// Top level of the glyph pixel blend block: input register, datapath, result register.
// Depends on gpb_pkg, gpb_cfg_regs and gpb_pixel_calc.
//
//   Port group   Direction  Flow control        Payload
//   in_*         in         valid / stall       gpb_in_t  (func, pos, coverage, background)
//   out_*        out        valid / stall       gpb_out_t (write_enable, address, pixel)
//   cfg_*        in         valid / ready       register index + 32-bit data
//
// One pixel per clock sustained while out is not stalled; a pixel passes through the input
// register and then the result register. The combinational datapath between them (12x13
// address multiply, three 8x8 blend multiplies) sets the clock period.
// Reset clears the valid flags and loads register defaults; payload registers are not reset.
// A stalled result is held in the result register while the input register still takes
// one more pixel; in_stall_o rises only when both registers are full and out is stalled.
`default_nettype none

module glyph_pixel_blend (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire gpb_pkg::gpb_in_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output gpb_pkg::gpb_out_t                   out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [gpb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [gpb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gpb_pkg::*;

  gpb_cfg_t cfg;
  gpb_in_t  s1_data_q;
  logic     s1_vld_q, s1_vld_d;
  gpb_out_t res;
  gpb_out_t out_data_q;
  logic     out_vld_q, out_vld_d;
  logic     s1_adv;
  logic     in_xfer;

  gpb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gpb_pixel_calc u_calc (
    .item_i (s1_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register frees up when empty or when its transfer completes
  assign s1_adv     = !out_vld_q || !out_stall_i;
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign s1_vld_d  = in_xfer || (s1_vld_q && !s1_adv);
  assign out_vld_d = s1_adv ? s1_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv && s1_vld_q) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/gpb_cfg_regs.sv -----
// Configuration register file: draw color, clip rectangle, line pitch.
// Depends on gpb_pkg.
`default_nettype none

module gpb_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [gpb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [gpb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output gpb_pkg::gpb_cfg_t                   cfg_o
);
  import gpb_pkg::*;

  gpb_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.draw_color  <= DRAW_COLOR_RST;
      cfg_q.clip_left   <= CLIP_LEFT_RST;
      cfg_q.clip_top    <= CLIP_TOP_RST;
      cfg_q.clip_right  <= CLIP_RIGHT_RST;
      cfg_q.clip_bottom <= CLIP_BOT_RST;
      cfg_q.line_pitch  <= LINE_PITCH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (gpb_reg_e'(cfg_index_i))
        REG_DRAW_COLOR:  cfg_q.draw_color  <= cfg_data_i[COLOR_W-1:0];
        REG_CLIP_LEFT:   cfg_q.clip_left   <= cfg_data_i[COORD_BITS-1:0];
        REG_CLIP_TOP:    cfg_q.clip_top    <= cfg_data_i[COORD_BITS-1:0];
        REG_CLIP_RIGHT:  cfg_q.clip_right  <= cfg_data_i[COORD_BITS-1:0];
        REG_CLIP_BOTTOM: cfg_q.clip_bottom <= cfg_data_i[COORD_BITS-1:0];
        REG_LINE_PITCH:  cfg_q.line_pitch  <= cfg_data_i[PITCH_W-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gpb_blend_chan.sv -----
// One 8-bit color channel: bg + (fg - bg) * a / 255, truncated toward zero.
// Depends on gpb_pkg.
`default_nettype none

module gpb_blend_chan (
  input  wire logic [7:0]              fg_i,
  input  wire logic [7:0]              bg_i,
  input  wire logic [gpb_pkg::COV_W-1:0] cov_i,
  output logic [7:0]                   chan_o
);
  import gpb_pkg::*;

  logic        neg;
  logic [7:0]  mag;
  logic [15:0] prod;
  logic [16:0] quot_sum;
  logic [7:0]  quot;

  // Work on |fg - bg| so the divide truncates toward zero for both signs.
  // x / 255 == (x + (x >> 8) + 1) >> 8 for every x up to 255 * 255, the largest product.
  always_comb begin
    neg      = (bg_i > fg_i);
    mag      = neg ? (bg_i - fg_i) : (fg_i - bg_i);
    prod     = 16'(mag) * 16'(cov_i);
    quot_sum = 17'(prod) + 17'(prod[15:8]) + 17'd1;
    quot     = quot_sum[15:8];
    chan_o   = neg ? (bg_i - quot) : (bg_i + quot);
  end

endmodule

`default_nettype wire

// ----- rtl/gpb_pixel_calc.sv -----
// Per-pixel datapath: clip test, address multiply-add, coverage blend.
// Depends on gpb_pkg and gpb_blend_chan.
`default_nettype none

module gpb_pixel_calc (
  input  wire gpb_pkg::gpb_in_t  item_i,
  input  wire gpb_pkg::gpb_cfg_t cfg_i,
  output gpb_pkg::gpb_out_t      res_o
);
  import gpb_pkg::*;

  localparam int unsigned PROD_W = COORD_BITS + PITCH_W;
  localparam int unsigned SUM_W  = ((PROD_W > ADDR_BITS) ? PROD_W : ADDR_BITS) + 1;

  logic [PROD_W-1:0] row_base;
  logic [SUM_W-1:0]  addr_sum;
  logic              in_clip;
  logic [7:0]        red, green, blue;

  gpb_blend_chan u_red (
    .fg_i   (cfg_i.draw_color[23:16]),
    .bg_i   (item_i.background[23:16]),
    .cov_i  (item_i.coverage),
    .chan_o (red)
  );

  gpb_blend_chan u_green (
    .fg_i   (cfg_i.draw_color[15:8]),
    .bg_i   (item_i.background[15:8]),
    .cov_i  (item_i.coverage),
    .chan_o (green)
  );

  gpb_blend_chan u_blue (
    .fg_i   (cfg_i.draw_color[7:0]),
    .bg_i   (item_i.background[7:0]),
    .cov_i  (item_i.coverage),
    .chan_o (blue)
  );

  always_comb begin
    row_base = PROD_W'(item_i.pos_y) * PROD_W'(cfg_i.line_pitch);
    addr_sum = SUM_W'(row_base) + SUM_W'(item_i.pos_x);

    // empty rectangle (left > right or top > bottom) falls out as never inside
    in_clip = (item_i.pos_x >= cfg_i.clip_left) && (item_i.pos_x <= cfg_i.clip_right) &&
              (item_i.pos_y >= cfg_i.clip_top)  && (item_i.pos_y <= cfg_i.clip_bottom);

    res_o.address      = addr_sum[ADDR_BITS-1:0];
    res_o.write_enable = 1'b0;
    res_o.pixel        = item_i.background;

    case (item_i.func)
      FUNC_FILL: begin
        res_o.write_enable = 1'b1;
        res_o.pixel        = cfg_i.draw_color;
      end
      FUNC_GLYPH: begin
        if (in_clip && (item_i.coverage != COV_NONE)) begin
          res_o.write_enable = 1'b1;
          if (item_i.coverage == COV_OPAQUE) begin
            res_o.pixel = cfg_i.draw_color;
          end else begin
            res_o.pixel = {item_i.background[31:24], red, green, blue};
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for glyph_pixel_blend: clocked driver and monitor around the block.
// Expected results come from a local pixel predictor. Depends on gpb_pkg and the block RTL.
module tb_top;
  import gpb_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200_000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_ITEMS  = 148;
  localparam int unsigned REPORT_MAX   = 10;
  // indexes past the last register, expected to be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid = 1'b0;
  gpb_in_t               in_data = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  gpb_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gpb_in_t  px_queue[$];
  gpb_out_t result_queue[$];
  gpb_cfg_t cfg;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  glyph_pixel_blend u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // bg + (fg - bg) * a / 255, division truncating toward zero
  function automatic logic [7:0] mix_channel(logic [7:0] fg, logic [7:0] bg, logic [7:0] a);
    int diff;
    diff = int'(fg) - int'(bg);
    return 8'(int'(bg) + (diff * int'(a)) / 255);
  endfunction

  function automatic gpb_out_t predict_pixel(gpb_in_t px);
    gpb_out_t res;
    logic     in_clip;
    res.address = ADDR_BITS'(longint'(px.pos_y) * longint'(cfg.line_pitch) +
                             longint'(px.pos_x));
    res.write_enable = 1'b0;
    res.pixel = px.background;
    if (px.func == FUNC_FILL) begin
      res.write_enable = 1'b1;
      res.pixel = cfg.draw_color;
    end else begin
      in_clip = px.pos_x >= cfg.clip_left && px.pos_x <= cfg.clip_right &&
                px.pos_y >= cfg.clip_top && px.pos_y <= cfg.clip_bottom;
      if (in_clip && px.coverage != COV_NONE) begin
        res.write_enable = 1'b1;
        if (px.coverage == COV_OPAQUE) begin
          res.pixel = cfg.draw_color;
        end else begin
          res.pixel = {px.background[31:24],
                       mix_channel(cfg.draw_color[23:16], px.background[23:16], px.coverage),
                       mix_channel(cfg.draw_color[15:8], px.background[15:8], px.coverage),
                       mix_channel(cfg.draw_color[7:0], px.background[7:0], px.coverage)};
        end
      end
    end
    return res;
  endfunction

  // driver: holds the payload while stalled, otherwise may idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        result_queue.push_back(predict_pixel(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (px_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= px_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result: we=%0b addr=%06h pixel=%08h",
                     out_data.write_enable, out_data.address, out_data.pixel);
        end else begin
          gpb_out_t exp;
          exp = result_queue.pop_front();
          if (out_data.write_enable !== exp.write_enable || out_data.address !== exp.address ||
              out_data.pixel !== exp.pixel) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("mismatch: exp we=%0b addr=%06h pixel=%08h, got we=%0b addr=%06h pixel=%08h",
                       exp.write_enable, exp.address, exp.pixel,
                       out_data.write_enable, out_data.address, out_data.pixel);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DRAW_COLOR:  cfg.draw_color = data;
      REG_CLIP_LEFT:   cfg.clip_left = data[COORD_BITS-1:0];
      REG_CLIP_TOP:    cfg.clip_top = data[COORD_BITS-1:0];
      REG_CLIP_RIGHT:  cfg.clip_right = data[COORD_BITS-1:0];
      REG_CLIP_BOTTOM: cfg.clip_bottom = data[COORD_BITS-1:0];
      REG_LINE_PITCH:  cfg.line_pitch = data[PITCH_W-1:0];
      default: ;
    endcase
  endtask

  // upper bits carry junk so the register masking is exercised
  function automatic logic [CFG_DATA_W-1:0] coord_word(int unsigned v);
    return ($urandom() & 32'hFFFF_F000) | (v & 32'h0000_0FFF);
  endfunction

  task automatic set_clip(int unsigned l, int unsigned t, int unsigned r, int unsigned b);
    write_reg(REG_CLIP_LEFT, coord_word(l));
    write_reg(REG_CLIP_TOP, coord_word(t));
    write_reg(REG_CLIP_RIGHT, coord_word(r));
    write_reg(REG_CLIP_BOTTOM, coord_word(b));
  endtask

  task automatic program_setting(int unsigned k);
    int unsigned l;
    int unsigned t;
    l = $urandom_range(0, 3800);
    t = $urandom_range(0, 3800);
    case (k)
      0: begin
        write_reg(REG_DRAW_COLOR, $urandom());
        set_clip(0, 0, 4095, 4095);
        write_reg(REG_LINE_PITCH, 32'd4096);
      end
      1: begin
        write_reg(REG_DRAW_COLOR, 32'hFFFF_FFFF);
        set_clip(l, t, l + $urandom_range(0, 295), t + $urandom_range(0, 295));
        write_reg(REG_LINE_PITCH, 32'd1);
      end
      2: begin
        // left past right: nothing inside
        write_reg(REG_DRAW_COLOR, 32'h0);
        set_clip(2000, 0, 1999, 4095);
        write_reg(REG_LINE_PITCH, 32'd0);
      end
      3: begin
        // top past bottom; pitch keeps its low 13 bits
        write_reg(REG_DRAW_COLOR, $urandom());
        set_clip(0, 3000, 4095, 10);
        write_reg(REG_LINE_PITCH, 32'hFFFF_FFFF);
      end
      4: begin
        write_reg(REG_DRAW_COLOR, $urandom());
        set_clip(4095, 0, 4095, 0);
        write_reg(REG_LINE_PITCH, $urandom_range(1, 4096));
      end
      default: begin
        write_reg(REG_DRAW_COLOR, $urandom());
        set_clip(l, t, l + $urandom_range(0, 4095 - l), t + $urandom_range(0, 4095 - t));
        write_reg(REG_LINE_PITCH, $urandom());
      end
    endcase
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
  endtask

  function automatic gpb_in_t make_px(gpb_func_e f, int unsigned x, int unsigned y,
                                      int unsigned cov, logic [COLOR_W-1:0] bg);
    gpb_in_t px;
    px.func = f;
    px.pos_x = x[COORD_BITS-1:0];
    px.pos_y = y[COORD_BITS-1:0];
    px.coverage = cov[COV_W-1:0];
    px.background = bg;
    return px;
  endfunction

  // favors the clip edges and their neighbors
  function automatic int unsigned pick_coord(logic [COORD_BITS-1:0] lo, logic [COORD_BITS-1:0] hi);
    logic [COORD_BITS-1:0] v;
    case ($urandom_range(5))
      0: v = lo - 1'b1;
      1: v = lo;
      2: v = hi;
      3: v = hi + 1'b1;
      4: v = COORD_BITS'($urandom_range(lo, hi));
      default: v = COORD_BITS'($urandom_range(0, 4095));
    endcase
    return 32'(v);
  endfunction

  function automatic int unsigned pick_coverage();
    case ($urandom_range(7))
      0: return 0;
      1: return 255;
      2: return 1;
      3: return 254;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i); while (px_queue.size() != 0 || in_valid || result_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    gpb_func_e f;
    cfg.draw_color = DRAW_COLOR_RST;
    cfg.clip_left = CLIP_LEFT_RST;
    cfg.clip_top = CLIP_TOP_RST;
    cfg.clip_right = CLIP_RIGHT_RST;
    cfg.clip_bottom = CLIP_BOT_RST;
    cfg.line_pitch = LINE_PITCH_RST;
    send_idle_pct = 32;
    stall_pct = 59;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // register defaults
    px_queue.push_back(make_px(FUNC_FILL, 4095, 4095, 0, 32'h1234_5678));
    px_queue.push_back(make_px(FUNC_GLYPH, 0, 0, 255, 32'hFFFF_FFFF));
    px_queue.push_back(make_px(FUNC_GLYPH, 4095, 4095, 0, 32'hA5A5_5A5A));
    wait_drained();

    write_reg(REG_DRAW_COLOR, 32'h80FF_0040);
    set_clip(100, 50, 200, 60);
    write_reg(REG_LINE_PITCH, 32'd4096);
    @(negedge clk_i);
    // coverage extremes, with channels above and below the draw color
    px_queue.push_back(make_px(FUNC_GLYPH, 150, 55, 255, 32'h0000_0000));
    px_queue.push_back(make_px(FUNC_GLYPH, 150, 55, 128, 32'hFF00_FF00));
    px_queue.push_back(make_px(FUNC_GLYPH, 150, 55, 1, 32'h7F80_80FF));
    px_queue.push_back(make_px(FUNC_GLYPH, 150, 55, 254, 32'h0000_FFFF));
    px_queue.push_back(make_px(FUNC_GLYPH, 150, 55, 0, 32'hDEAD_BEEF));
    // clip edges, inside and just outside
    px_queue.push_back(make_px(FUNC_GLYPH, 99, 55, 200, 32'h1111_1111));
    px_queue.push_back(make_px(FUNC_GLYPH, 100, 55, 200, 32'h2222_2222));
    px_queue.push_back(make_px(FUNC_GLYPH, 200, 55, 200, 32'h3333_3333));
    px_queue.push_back(make_px(FUNC_GLYPH, 201, 55, 200, 32'h4444_4444));
    px_queue.push_back(make_px(FUNC_GLYPH, 150, 49, 200, 32'h5555_5555));
    px_queue.push_back(make_px(FUNC_GLYPH, 150, 50, 200, 32'h6666_6666));
    px_queue.push_back(make_px(FUNC_GLYPH, 150, 60, 200, 32'h7777_7777));
    px_queue.push_back(make_px(FUNC_GLYPH, 150, 61, 200, 32'h8888_8888));
    // fill ignores clip and coverage; far corner hits the top address
    px_queue.push_back(make_px(FUNC_FILL, 0, 0, 0, 32'h9999_9999));
    px_queue.push_back(make_px(FUNC_FILL, 4095, 4095, 255, 32'hFFFF_FFFF));
    px_queue.push_back(make_px(FUNC_GLYPH, 4095, 4095, 255, 32'hFFFF_FFFF));
    px_queue.push_back(make_px(FUNC_GLYPH, 0, 0, 255, 32'h0));
    wait_drained();

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph / 3)
        0: begin send_idle_pct = 32; stall_pct = 59; end
        1: begin send_idle_pct = 59; stall_pct = 32; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      program_setting(ph);
      @(negedge clk_i);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        f = ($urandom_range(3) == 0) ? FUNC_FILL : FUNC_GLYPH;
        px_queue.push_back(make_px(f, pick_coord(cfg.clip_left, cfg.clip_right),
                                   pick_coord(cfg.clip_top, cfg.clip_bottom),
                                   pick_coverage(), $urandom()));
      end
      wait_drained();
    end

    if (result_queue.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
